// ===== rtl/core/cdwa_pkg.sv =====
// ----------------------------------------------------------------------------
// cdwa_pkg
// Shared types and constants for the counter delta weighted average unit.
// ----------------------------------------------------------------------------
package cdwa_pkg;

   // field widths
   localparam int unsigned COUNT_W = 16;
   localparam int unsigned RATE_W  = 16;

   // filter taps, oldest first, weights sum to WEIGHT_TOTAL
   localparam int unsigned TAPS      = 10;
   localparam int unsigned HALF_TAPS = TAPS / 2;
   localparam int unsigned WEIGHT_W  = 11;
   localparam logic [WEIGHT_W-1:0] TAP_WEIGHT [TAPS] = '{
      11'd10, 11'd20, 11'd20, 11'd25, 11'd25,
      11'd50, 11'd50, 11'd100, 11'd300, 11'd1400
   };
   localparam int unsigned WEIGHT_TOTAL = 2000;

   // saturation: any sum at or above this divides to more than RATE_MAX
   localparam int unsigned SAT_LIMIT = WEIGHT_TOTAL * 65536;
   localparam int unsigned SAT_W     = 27;
   localparam logic [RATE_W-1:0] RATE_MAX = '1;

   // divide by 2000 = shift by 4, then multiply by reciprocal of 125
   localparam int unsigned PRE_SHIFT = 4;
   localparam int unsigned X_W       = SAT_W - PRE_SHIFT;
   localparam int unsigned DIV_SHIFT = 30;
   localparam int unsigned MULT_W    = 24;
   localparam logic [MULT_W-1:0] DIV_MULT = 24'd8589935;
   localparam int unsigned PROD_W    = X_W + MULT_W;

   // pipeline advance strobes
   typedef struct packed {
      logic hist;
      logic s1;
      logic s2;
      logic s3;
      logic out;
   } stage_en_type;

endpackage

// ===== rtl/core/cdwa_req_if.sv =====
// ----------------------------------------------------------------------------
// cdwa_req_if
// Request channel: three raw counter readings with valid/ready handshake.
// ----------------------------------------------------------------------------
interface cdwa_req_if;

   logic                         valid;
   logic                         ready;
   logic [cdwa_pkg::COUNT_W-1:0] left_count;
   logic [cdwa_pkg::COUNT_W-1:0] middle_count;
   logic [cdwa_pkg::COUNT_W-1:0] right_count;

   modport source (
      output valid, left_count, middle_count, right_count,
      input  ready
   );

   modport sink (
      input  valid, left_count, middle_count, right_count,
      output ready
   );

endinterface

// ===== rtl/core/cdwa_rsp_if.sv =====
// ----------------------------------------------------------------------------
// cdwa_rsp_if
// Response channel: three averaged rates with valid/ready handshake.
// ----------------------------------------------------------------------------
interface cdwa_rsp_if;

   logic                        valid;
   logic                        ready;
   logic [cdwa_pkg::RATE_W-1:0] left_rate;
   logic [cdwa_pkg::RATE_W-1:0] middle_rate;
   logic [cdwa_pkg::RATE_W-1:0] right_rate;

   modport source (
      output valid, left_rate, middle_rate, right_rate,
      input  ready
   );

   modport sink (
      input  valid, left_rate, middle_rate, right_rate,
      output ready
   );

endinterface

// ===== rtl/core/cdwa_channel.sv =====
// ----------------------------------------------------------------------------
// cdwa_channel
// One channel datapath: counter delta, 10-tap history, weighted sum, divide
// by 2000 with saturation.
// ----------------------------------------------------------------------------
module cdwa_channel #(
   parameter int unsigned COUNTER_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cdwa_pkg::stage_en_type        en,
   input  logic [cdwa_pkg::COUNT_W-1:0]  count_in,
   output logic [cdwa_pkg::RATE_W-1:0]   rate_out
);

   localparam int unsigned SUM_W = COUNTER_BITS + cdwa_pkg::WEIGHT_W;
   localparam int unsigned CMP_W = (SUM_W > cdwa_pkg::SAT_W) ? SUM_W : cdwa_pkg::SAT_W;

   logic [COUNTER_BITS-1:0] now;
   logic [COUNTER_BITS-1:0] delta;
   logic [COUNTER_BITS-1:0] prev_ff;
   logic [COUNTER_BITS-1:0] hist_ff [cdwa_pkg::TAPS];

   logic [SUM_W-1:0] psum_lo_in, psum_lo_ff;
   logic [SUM_W-1:0] psum_hi_in, psum_hi_ff;

   logic [SUM_W-1:0]           total;
   logic [CMP_W-1:0]           total_ext;
   logic [cdwa_pkg::X_W-1:0]   x_ff;
   logic                       sat2_ff;

   logic [cdwa_pkg::PROD_W-1:0] prod_in, prod_ff;
   logic                        sat3_ff;

   logic [cdwa_pkg::RATE_W-1:0] rate_in, rate_ff;

   // modular delta against previous reading
   assign now   = COUNTER_BITS'(count_in);
   assign delta = now - prev_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
         for (int t = 0; t < cdwa_pkg::TAPS; t++) begin
            hist_ff[t] <= '0;
         end
      end else if (en.hist) begin
         prev_ff <= now;
         for (int t = 0; t < cdwa_pkg::TAPS - 1; t++) begin
            hist_ff[t] <= hist_ff[t+1];
         end
         hist_ff[cdwa_pkg::TAPS-1] <= delta;
      end
   end

   // weighted partial sums, older and newer half
   always_comb begin
      psum_lo_in = '0;
      psum_hi_in = '0;
      for (int t = 0; t < cdwa_pkg::HALF_TAPS; t++) begin
         psum_lo_in = psum_lo_in
                    + SUM_W'(hist_ff[t]) * SUM_W'(cdwa_pkg::TAP_WEIGHT[t]);
         psum_hi_in = psum_hi_in
                    + SUM_W'(hist_ff[t + cdwa_pkg::HALF_TAPS])
                    * SUM_W'(cdwa_pkg::TAP_WEIGHT[t + cdwa_pkg::HALF_TAPS]);
      end
   end

   assign total     = psum_lo_ff + psum_hi_ff;
   assign total_ext = CMP_W'(total);

   assign prod_in = cdwa_pkg::PROD_W'(x_ff) * cdwa_pkg::PROD_W'(cdwa_pkg::DIV_MULT);
   assign rate_in = sat3_ff ? cdwa_pkg::RATE_MAX
                            : prod_ff[cdwa_pkg::DIV_SHIFT +: cdwa_pkg::RATE_W];

   always_ff @(posedge clock) begin
      if (en.s1) begin
         psum_lo_ff <= psum_lo_in;
         psum_hi_ff <= psum_hi_in;
      end
      if (en.s2) begin
         x_ff    <= total_ext[cdwa_pkg::PRE_SHIFT +: cdwa_pkg::X_W];
         sat2_ff <= (total_ext >= CMP_W'(cdwa_pkg::SAT_LIMIT));
      end
      if (en.s3) begin
         prod_ff <= prod_in;
         sat3_ff <= sat2_ff;
      end
      if (en.out) begin
         rate_ff <= rate_in;
      end
   end

   assign rate_out = rate_ff;

endmodule

// ===== rtl/core/counter_delta_weighted_average_unit.sv =====
// ----------------------------------------------------------------------------
// counter_delta_weighted_average_unit
// Three-channel weighted moving average of free-running pulse counter deltas.
// ----------------------------------------------------------------------------
// Each request on req_chan carries one raw reading per counter (left, middle,
// right). Per channel the unit takes the difference from the previous
// reading modulo 2^COUNTER_BITS, shifts it into a ten-deep history and
// returns on rsp_chan the sum weighted 10,20,20,25,25,50,50,100,300,1400
// (oldest first) divided by 2000, truncated, saturated at 65535.
// Exactly one response follows every request, in order.
// A request passes from the accepting edge to rsp_chan.valid through the
// history update, partial sums, total and saturation check, reciprocal
// multiply and response register.
// Throughput: one request per cycle; each stage has its own valid bit and
// takes a new request whenever the stage ahead moves or is empty.
// When the receiver stalls the response holds and stages fill up; once all
// five are full req_chan.ready drops until the response is taken.
// Reset clears the previous readings, the history and all valid bits; the
// first delta after reset equals the raw reading.
// ----------------------------------------------------------------------------
module counter_delta_weighted_average_unit #(
   parameter int unsigned COUNTER_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   cdwa_req_if.sink   req_chan,
   cdwa_rsp_if.source rsp_chan
);

   logic v1_ff, v2_ff, v3_ff, v4_ff, rsp_valid_ff;
   logic take1, take2, take3, out_adv;
   cdwa_pkg::stage_en_type en;

   assign out_adv = !rsp_valid_ff || rsp_chan.ready;
   assign take3   = !v4_ff || out_adv;
   assign take2   = !v3_ff || take3;
   assign take1   = !v2_ff || take2;

   assign req_chan.ready = !v1_ff || take1;

   assign en.hist = req_chan.valid && req_chan.ready;
   assign en.s1   = take1;
   assign en.s2   = take2;
   assign en.s3   = take3;
   assign en.out  = out_adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_chan.ready) v1_ff <= req_chan.valid;
         if (take1)          v2_ff <= v1_ff;
         if (take2)          v3_ff <= v2_ff;
         if (take3)          v4_ff <= v3_ff;
         if (out_adv)        rsp_valid_ff <= v4_ff;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;

   cdwa_channel #(.COUNTER_BITS(COUNTER_BITS)) u_left (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .count_in (req_chan.left_count),
      .rate_out (rsp_chan.left_rate)
   );

   cdwa_channel #(.COUNTER_BITS(COUNTER_BITS)) u_middle (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .count_in (req_chan.middle_count),
      .rate_out (rsp_chan.middle_rate)
   );

   cdwa_channel #(.COUNTER_BITS(COUNTER_BITS)) u_right (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .count_in (req_chan.right_count),
      .rate_out (rsp_chan.right_rate)
   );

endmodule

// ===== rtl/core/cdwa_checker.sv =====
// ----------------------------------------------------------------------------
// cdwa_checker
// Port-level checks for the counter delta weighted average unit.
// ----------------------------------------------------------------------------
module cdwa_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [cdwa_pkg::RATE_W-1:0] left_rate,
   input logic [cdwa_pkg::RATE_W-1:0] middle_rate,
   input logic [cdwa_pkg::RATE_W-1:0] right_rate
);

   logic       req_acc, rsp_acc;
   logic [2:0] pending_ff;

   assign req_acc = req_valid && req_ready;
   assign rsp_acc = rsp_valid && rsp_ready;

   // requests in flight
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_ff + 3'(req_acc) - 3'(rsp_acc);
      end
   end

   a_no_rsp_without_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 3'd0)
      else $error("response with no request in flight");

   a_depth: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= 3'd5)
      else $error("more requests in flight than pipeline stages");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_acc && rsp_ready ##1 rsp_ready ##1 rsp_ready ##1 rsp_ready ##1 rsp_ready
      |=> rsp_valid)
      else $error("response late with receiver ready");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(left_rate)
                                  && $stable(middle_rate) && $stable(right_rate))
      else $error("stalled response changed");

endmodule

bind counter_delta_weighted_average_unit cdwa_checker u_cdwa_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .left_rate   (rsp_chan.left_rate),
   .middle_rate (rsp_chan.middle_rate),
   .right_rate  (rsp_chan.right_rate)
);

// ===== dv/tb_counter_delta_weighted_average_unit.sv =====
// ----------------------------------------------------------------------------
// tb_counter_delta_weighted_average_unit
// Self-checking bench for the three-channel counter delta weighted average.
// ----------------------------------------------------------------------------
// A short table of directed requests covers the post-reset state, the all-ones
// reading, a zero delta, a wrap by one count and a window full of maximum
// deltas. Random bursts of counter readings follow: steady rates with jitter,
// wrapping rates and raw noise. A local model of the delta history predicts
// every response. The sender idles in random bursts, the receiver stalls in
// shifting patterns, and midway and at random the sender lets the pipeline empty.
// ----------------------------------------------------------------------------
module tb_counter_delta_weighted_average_unit;

   localparam int unsigned CHANNELS     = 3;
   localparam int unsigned WINDOW       = 10;
   localparam int unsigned WEIGHT_SUM   = 2000;
   localparam int unsigned WEIGHTS [WINDOW] = '{10, 20, 20, 25, 25, 50, 50, 100, 300, 1400};
   localparam longint unsigned RATE_CEIL = 65535;
   localparam int CH_LEFT      = 0;
   localparam int CH_MIDDLE    = 1;
   localparam int CH_RIGHT     = 2;
   localparam int RANDOM_ITEMS = 500;
   localparam int IDLE_LIMIT   = 5000;
   localparam int TAIL_CYCLES  = 16;
   localparam int DIRECTED_LEN = 22;

   typedef logic [cdwa_pkg::COUNT_W-1:0] count_type;
   typedef logic [cdwa_pkg::RATE_W-1:0]  rate_type;

   typedef struct packed {
      count_type left;
      count_type middle;
      count_type right;
   } readings_type;

   typedef struct packed {
      rate_type left;
      rate_type middle;
      rate_type right;
   } rates_type;

   typedef struct packed {
      readings_type readings;
      logic         typed;
      rates_type    rates;
   } directed_row_type;

   typedef enum int {STALL_NONE, STALL_RANDOM, STALL_HEAVY, STALL_TOGGLE} stall_mode_type;

   localparam directed_row_type DIRECTED_ROWS [DIRECTED_LEN] = '{
      // after reset
      '{'{16'h0000, 16'h0000, 16'h0000}, 1'b1, '{16'd0, 16'd0, 16'd0}},
      // first delta is the raw reading
      '{'{16'hffff, 16'hffff, 16'hffff}, 1'b1, '{16'd45874, 16'd45874, 16'd45874}},
      // zero delta
      '{'{16'hffff, 16'hffff, 16'hffff}, 1'b1, '{16'd9830, 16'd9830, 16'd9830}},
      // wrap by one count
      '{'{16'h0000, 16'h0000, 16'h0000}, 1'b1, '{16'd3277, 16'd3277, 16'd3277}},
      // maximum delta on every step
      '{'{16'hffff, 16'hffff, 16'hffff}, 1'b0, '0},
      '{'{16'hfffe, 16'hfffe, 16'hfffe}, 1'b0, '0},
      '{'{16'hfffd, 16'hfffd, 16'hfffd}, 1'b0, '0},
      '{'{16'hfffc, 16'hfffc, 16'hfffc}, 1'b0, '0},
      '{'{16'hfffb, 16'hfffb, 16'hfffb}, 1'b0, '0},
      '{'{16'hfffa, 16'hfffa, 16'hfffa}, 1'b0, '0},
      '{'{16'hfff9, 16'hfff9, 16'hfff9}, 1'b0, '0},
      '{'{16'hfff8, 16'hfff8, 16'hfff8}, 1'b0, '0},
      '{'{16'hfff7, 16'hfff7, 16'hfff7}, 1'b0, '0},
      // full window of maximum deltas
      '{'{16'hfff6, 16'hfff6, 16'hfff6}, 1'b1, '{16'd65535, 16'd65535, 16'd65535}},
      // mixed channels: steady climb, alternating bits, decay and jumps
      '{'{16'h03f6, 16'h5555, 16'hfff6}, 1'b0, '0},
      '{'{16'h07f6, 16'haaaa, 16'hfff6}, 1'b0, '0},
      '{'{16'h0bf6, 16'h5555, 16'h0001}, 1'b0, '0},
      '{'{16'h0ff6, 16'haaaa, 16'h8000}, 1'b0, '0},
      '{'{16'h13f6, 16'h5555, 16'h7fff}, 1'b0, '0},
      '{'{16'h17f6, 16'haaaa, 16'h0000}, 1'b0, '0},
      '{'{16'h1bf6, 16'h5555, 16'hffff}, 1'b0, '0},
      '{'{16'h1ff6, 16'haaaa, 16'hfff6}, 1'b0, '0}
   };

   logic clock;
   logic reset;

   cdwa_req_if req_chan ();
   cdwa_rsp_if rsp_chan ();

   counter_delta_weighted_average_unit uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // local copy of the filter state
   count_type last_reading [CHANNELS]          = '{default: '0};
   count_type delta_window [CHANNELS][WINDOW]  = '{default: '{default: '0}};

   // random sender state
   count_type sent_count   [CHANNELS]          = '{default: '0};
   count_type channel_step [CHANNELS]          = '{default: '0};

   rates_type pending_rates [$];
   int        mismatch_count = 0;
   int        idle_cycles    = 0;

   function automatic rate_type advance_channel(input int ch, input count_type reading);
      count_type       delta;
      longint unsigned acc;
      int              t;
      delta = reading - last_reading[ch];
      last_reading[ch] = reading;
      for (t = 0; t < WINDOW - 1; t++)
         delta_window[ch][t] = delta_window[ch][t + 1];
      delta_window[ch][WINDOW - 1] = delta;
      acc = 0;
      for (t = 0; t < WINDOW; t++)
         acc += 64'(delta_window[ch][t]) * 64'(WEIGHTS[t]);
      acc = acc / WEIGHT_SUM;
      if (acc > RATE_CEIL)
         acc = RATE_CEIL;
      return rate_type'(acc);
   endfunction

   function automatic rates_type predict_rates(input readings_type r);
      rates_type p;
      p.left   = advance_channel(CH_LEFT, r.left);
      p.middle = advance_channel(CH_MIDDLE, r.middle);
      p.right  = advance_channel(CH_RIGHT, r.right);
      return p;
   endfunction

   function automatic void pick_channel_steps();
      int c;
      for (c = 0; c < CHANNELS; c++) begin
         case ($urandom_range(0, 3))
            0:       channel_step[c] = count_type'($urandom_range(0, 40));
            1:       channel_step[c] = count_type'($urandom_range(0, 3000));
            2:       channel_step[c] = count_type'($urandom_range(60000, 65535));
            default: channel_step[c] = count_type'($urandom);
         endcase
      end
   endfunction

   function automatic count_type next_count(input int ch);
      if ($urandom_range(0, 6) == 0)
         sent_count[ch] = count_type'($urandom);
      else
         sent_count[ch] = sent_count[ch] + channel_step[ch]
                        + count_type'($urandom_range(0, 15));
      return sent_count[ch];
   endfunction

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_readings(input readings_type r, input logic typed,
                                input rates_type typed_rates);
      rates_type predicted;
      req_chan.valid        <= 1'b1;
      req_chan.left_count   <= r.left;
      req_chan.middle_count <= r.middle;
      req_chan.right_count  <= r.right;
      do
         @(posedge clock);
      while (!(req_chan.valid && req_chan.ready));
      predicted = predict_rates(r);
      pending_rates.push_back(typed ? typed_rates : predicted);
      @(negedge clock);
   endtask

   task automatic pause_sender(input int cycles);
      req_chan.valid <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   task automatic drain_pipeline();
      req_chan.valid <= 1'b0;
      do
         @(negedge clock);
      while (pending_rates.size() != 0);
   endtask

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // receiver stall patterns
   initial begin
      stall_mode_type mode;
      int             span;
      rsp_chan.ready = 1'b0;
      forever begin
         mode = stall_mode_type'($urandom_range(0, 3));
         span = $urandom_range(4, 60);
         repeat (span) begin
            @(negedge clock);
            case (mode)
               STALL_NONE:   rsp_chan.ready <= 1'b1;
               STALL_RANDOM: rsp_chan.ready <= ($urandom_range(0, 1) == 1);
               STALL_HEAVY:  rsp_chan.ready <= ($urandom_range(0, 7) == 0);
               default:      rsp_chan.ready <= ~rsp_chan.ready;
            endcase
         end
      end
   end

   always @(posedge clock) begin : check_rates
      rates_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_rates.size() == 0) begin
            $error("unexpected response: left_rate %0d middle_rate %0d right_rate %0d",
                   rsp_chan.left_rate, rsp_chan.middle_rate, rsp_chan.right_rate);
            mismatch_count++;
         end else begin
            want = pending_rates.pop_front();
            if (rsp_chan.left_rate !== want.left) begin
               $error("left_rate mismatch: expected %0d, actual %0d",
                      want.left, rsp_chan.left_rate);
               mismatch_count++;
            end
            if (rsp_chan.middle_rate !== want.middle) begin
               $error("middle_rate mismatch: expected %0d, actual %0d",
                      want.middle, rsp_chan.middle_rate);
               mismatch_count++;
            end
            if (rsp_chan.right_rate !== want.right) begin
               $error("right_rate mismatch: expected %0d, actual %0d",
                      want.right, rsp_chan.right_rate);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      readings_type r;
      int           row;
      int           n;
      int           gap;
      int           burst_left;
      reset                 = 1'b1;
      req_chan.valid        = 1'b0;
      req_chan.left_count   = '0;
      req_chan.middle_count = '0;
      req_chan.right_count  = '0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (row = 0; row < DIRECTED_LEN; row++)
         send_readings(DIRECTED_ROWS[row].readings, DIRECTED_ROWS[row].typed,
                       DIRECTED_ROWS[row].rates);

      burst_left = 0;
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 2 || $urandom_range(0, 149) == 0)
            drain_pipeline();
         if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
            gap = $urandom_range(0, 5);
            if (gap != 0)
               pause_sender(gap);
            pick_channel_steps();
         end
         burst_left--;
         r.left   = next_count(CH_LEFT);
         r.middle = next_count(CH_MIDDLE);
         r.right  = next_count(CH_RIGHT);
         send_readings(r, 1'b0, '0);
      end

      req_chan.valid <= 1'b0;
      while (pending_rates.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
